[rtl/core/utf8_to_ucs2_decoder_unit_assert.svh]
// Assertion macros for the UTF-8 to UCS-2 decoder unit.
// Used by u2u_back, which checks its own state; compiled out under SYNTH.
`ifndef UTF8_TO_UCS2_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define U2U_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define U2U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define U2U_ASSERT(lbl, clk, rst_n, prop, msg)
`define U2U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/core/u2u_pkg.sv]
// Shared types and constants of the UTF-8 to UCS-2 decoder unit.
// Used by the front classifier, the token queue, the back decoder and the top level.
package u2u_pkg;

	localparam int unsigned U2U_QUEUE_DEPTH = 2;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned UNIT_W          = 16;
	localparam int unsigned STATUS_W        = 3;
	localparam int unsigned PARTIAL_W       = 10;
	localparam int unsigned PAYLOAD_W       = 7;
	localparam int unsigned CONT_W          = 6;

	// Byte classes as seen in isolation
	typedef enum logic [2:0] {
		TK_NUL,
		TK_ASCII,
		TK_LEAD2,
		TK_LEAD3,
		TK_LEAD4,
		TK_CONT,
		TK_BADLEAD
	} tok_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_UNIT      = 3'd0,
		ST_END_OK    = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_BAD_CONT  = 3'd3,
		ST_BAD_LEAD  = 3'd4,
		ST_FOUR_BYTE = 3'd5
	} status_t;

	// Classified byte: kind plus the payload bits that kind carries
	typedef struct packed {
		tok_kind_t              kind;
		logic [PAYLOAD_W-1:0]   bits;
	} token_t;

	// Handshake between the front and the queue
	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

endpackage

[rtl/core/utf8_to_ucs2_decoder_unit.sv]
// Top level of the UTF-8 to UCS-2 decoder unit.
// Depends on u2u_pkg, u2u_front, u2u_queue and u2u_back.
//
// Usage:
//   Input stream  s_*: one UTF-8 byte per transaction in s_tdata[7:0]; a zero
//   byte ends the current string.
//   Output stream m_*: zero or one result per byte. m_tdata carries the UCS-2
//   code unit, m_tuser the status (unit, end ok, empty string, bad
//   continuation, invalid lead, four-byte lead). The code unit is zero for
//   every status but unit.
//   Throughput: one byte per cycle, sustained while m_tready stays high.
//   A taken byte is first stored in a queue entry; the back then pops it and
//   loads its result into the output register that drives m_*, once the
//   queue has passed on any older bytes.
//   The front classifies each byte on its own and pushes a token into a
//   queue of QUEUE_DEPTH entries; the back pops one token a cycle while the
//   output is free, updates the sequence state and loads the output register.
//   When the receiver stalls, the output register holds its result, the back
//   stops popping and the queue fills; s_tready drops once it is full.
//   After a fault the back drops bytes silently through the next zero byte.
//   Reset (arst_n low) empties the queue and output register and starts a
//   fresh string; no clearing pass is needed.
module utf8_to_ucs2_decoder_unit import u2u_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = U2U_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [UNIT_W-1:0]   m_tdata,   // [15:0] code_unit
	output logic [STATUS_W-1:0] m_tuser    // [2:0] status
);

	qctl_t  qctl;
	token_t wr_tok;
	token_t rd_tok;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;

	// Accept and classify bytes
	u2u_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.qctl     (qctl),
		.tok      (wr_tok)
	);

	// Decouple the two sides so either can stall on its own
	u2u_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.qctl     (qctl),
		.wr_tok   (wr_tok),
		.full     (q_full),
		.rd_valid (q_valid),
		.pop      (q_pop),
		.rd_tok   (rd_tok)
	);

	// Advance the sequence state and register results
	u2u_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (q_valid),
		.rd_tok   (rd_tok),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[rtl/core/u2u_front.sv]
// Front stage of the UTF-8 to UCS-2 decoder: accepts bytes and classifies them.
// Depends on u2u_pkg; feeds u2u_queue.
module u2u_front import u2u_pkg::*; (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic              q_full,
	output qctl_t             qctl,
	output token_t            tok
);

	always_comb begin
		s_tready  = !q_full;
		qctl.full = q_full;
		qctl.push = s_tvalid && !q_full;
	end

	always_comb begin
		tok.kind = TK_BADLEAD;
		tok.bits = '0;
		priority if (s_tdata == '0) begin
			tok.kind = TK_NUL;
		end else if (!s_tdata[7]) begin
			tok.kind = TK_ASCII;
			tok.bits = s_tdata[6:0];
		end else if (s_tdata[7:6] == 2'b10) begin
			tok.kind = TK_CONT;
			tok.bits = {1'b0, s_tdata[5:0]};
		end else if (s_tdata[7:5] == 3'b110) begin
			tok.kind = TK_LEAD2;
			tok.bits = {2'b00, s_tdata[4:0]};
		end else if (s_tdata[7:4] == 4'b1110) begin
			tok.kind = TK_LEAD3;
			tok.bits = {3'b000, s_tdata[3:0]};
		end else if (s_tdata[7:3] == 5'b11110) begin
			tok.kind = TK_LEAD4;
		end else begin
			tok.kind = TK_BADLEAD;
		end
	end

endmodule

[rtl/core/u2u_queue.sv]
// Short token queue between the front classifier and the back decoder.
// Depends on u2u_pkg for the token type.
module u2u_queue import u2u_pkg::*; #(
	parameter int unsigned DEPTH = U2U_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  qctl_t  qctl,
	input  token_t wr_tok,
	output logic   full,
	output logic   rd_valid,
	input  logic   pop,
	output token_t rd_tok
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	token_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign full     = (count_q == FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_tok   = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (qctl.push) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qctl.push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({qctl.push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/u2u_back.sv]
// Back stage of the UTF-8 to UCS-2 decoder: sequence state and result register.
// Depends on u2u_pkg and the assertion macros header.
`include "utf8_to_ucs2_decoder_unit_assert.svh"
module u2u_back import u2u_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_valid,
	input  token_t              rd_tok,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [UNIT_W-1:0]   m_tdata,   // [15:0] code_unit
	output logic [STATUS_W-1:0] m_tuser    // [2:0] status
);

	logic [1:0]            pend_q;
	logic [PARTIAL_W-1:0]  partial_q;
	logic                  start_q;
	logic                  skip_q;
	logic                  out_valid_q;
	logic [UNIT_W-1:0]     unit_q;
	status_t               status_q;

	logic [1:0]            pend_d;
	logic [PARTIAL_W-1:0]  partial_d;
	logic                  start_d;
	logic                  skip_d;
	logic                  emit;
	logic [UNIT_W-1:0]     unit_d;
	status_t               status_d;
	logic [CONT_W-1:0]     cont;

	assign pop  = rd_valid && (!out_valid_q || m_tready);
	assign cont = rd_tok.bits[CONT_W-1:0];

	always_comb begin
		pend_d    = pend_q;
		partial_d = partial_q;
		start_d   = start_q;
		skip_d    = skip_q;
		emit      = 1'b0;
		unit_d    = '0;
		status_d  = ST_UNIT;
		priority if (skip_q) begin
			if (rd_tok.kind == TK_NUL) begin
				skip_d    = 1'b0;
				start_d   = 1'b1;
				pend_d    = '0;
				partial_d = '0;
			end
		end else if (pend_q != '0) begin
			priority if (rd_tok.kind == TK_NUL) begin
				emit = 1'b1; status_d = ST_BAD_CONT;
				pend_d = '0; partial_d = '0; start_d = 1'b1;
			end else if (rd_tok.kind != TK_CONT) begin
				emit = 1'b1; status_d = ST_BAD_CONT;
				pend_d = '0; partial_d = '0; start_d = 1'b1; skip_d = 1'b1;
			end else if (pend_q == 2'd1) begin
				emit      = 1'b1;
				unit_d    = {partial_q, cont};
				pend_d    = '0;
				partial_d = '0;
			end else begin
				partial_d = {partial_q[PARTIAL_W-CONT_W-1:0], cont};
				pend_d    = pend_q - 2'd1;
			end
		end else begin
			unique case (rd_tok.kind)
				TK_NUL: begin
					emit      = 1'b1;
					status_d  = start_q ? ST_EMPTY : ST_END_OK;
					start_d   = 1'b1;
					partial_d = '0;
				end
				TK_ASCII: begin
					emit    = 1'b1;
					unit_d  = {{(UNIT_W-PAYLOAD_W){1'b0}}, rd_tok.bits};
					start_d = 1'b0;
				end
				TK_LEAD2: begin
					start_d   = 1'b0;
					partial_d = {{(PARTIAL_W-5){1'b0}}, rd_tok.bits[4:0]};
					pend_d    = 2'd1;
				end
				TK_LEAD3: begin
					start_d   = 1'b0;
					partial_d = {{(PARTIAL_W-4){1'b0}}, rd_tok.bits[3:0]};
					pend_d    = 2'd2;
				end
				TK_LEAD4: begin
					emit = 1'b1; status_d = ST_FOUR_BYTE;
					pend_d = '0; partial_d = '0; start_d = 1'b1; skip_d = 1'b1;
				end
				default: begin
					emit = 1'b1; status_d = ST_BAD_LEAD;
					pend_d = '0; partial_d = '0; start_d = 1'b1; skip_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			partial_q   <= '0;
			start_q     <= 1'b1;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pend_q      <= pend_d;
				partial_q   <= partial_d;
				start_q     <= start_d;
				skip_q      <= skip_d;
				out_valid_q <= emit;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			unit_q   <= unit_d;
			status_q <= status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = unit_q;
	assign m_tuser  = status_q;

	`U2U_ASSERT(a_no_pend_while_skip, clk, arst_n, !(skip_q && pend_q != '0), "pending bytes while discarding")
	`U2U_ASSERT(a_pend_range, clk, arst_n, pend_q != 2'd3, "pending count out of range")
	`U2U_ASSERT(a_pend_not_start, clk, arst_n, (pend_q == '0) || !start_q, "pending bytes at string start")
	`U2U_ASSERT(a_err_unit_zero, clk, arst_n, !(out_valid_q && status_q != ST_UNIT) || (unit_q == '0), "nonzero code unit on status")
	`U2U_ASSERT_NEXT(a_skip_silent, clk, arst_n, pop && skip_q, !out_valid_q, "result while discarding")

endmodule
